### rtl/core/spq_pkg.sv
package spq_pkg;

    // Request command codes.
    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_EXTRACT = 2'd1;
    localparam logic [1:0] CMD_PEEK    = 2'd2;

    // Result status codes.
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_EMPTY = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;

    // Fixed field widths of the request and result ports.
    localparam int SEV_W = 8;
    localparam int TAG_W = 16;
    localparam int SEQ_W = 32;
    localparam int OCC_W = 5;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } t_state;

endpackage

### rtl/core/stable_priority_queue.sv
// Channel   Direction  Handshake                Payload
// request   in         i_in_valid / o_in_stall  i_command, i_severity, i_tag
// result    out        o_out_valid / i_out_stall o_status, o_out_severity, o_out_tag,
//                                               o_arrival_seq, o_occupancy, o_queue_empty
//
// Insert, ignored commands and extract or peek on an empty queue go straight
// to the result state. Peek scans the occupied slots; extract scans them and
// then closes the gap behind the selected slot: one memory read per cycle
// for the scan, then one read and one write per cycle for the gap closing.
// Reset is synchronous and clears the state, fill count, sequence counter
// and output valid only; the entry memory is not cleared. A stalled result
// waits in the output register while the next request is already being worked on.
module stable_priority_queue #(
    parameter int CAPACITY = 16,
    parameter int TAG_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_command,
    input  logic [spq_pkg::SEV_W-1:0] i_severity,
    input  logic [spq_pkg::TAG_W-1:0] i_tag,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [1:0]                o_status,
    output logic [spq_pkg::SEV_W-1:0] o_out_severity,
    output logic [spq_pkg::TAG_W-1:0] o_out_tag,
    output logic [spq_pkg::SEQ_W-1:0] o_arrival_seq,
    output logic [spq_pkg::OCC_W-1:0] o_occupancy,
    output logic                      o_queue_empty
);

    import spq_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int TW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam int DW = SEV_W + TW + SEQ_W;

    t_state r_state, n_state;

    logic [CW-1:0]    r_count;
    logic [SEQ_W-1:0] r_next_seq;
    logic [CW-1:0]    r_ptr;
    logic             r_rd_vld;
    logic [IW-1:0]    r_rd_idx;
    logic [1:0]       r_cmd;

    logic [1:0]       r_status;
    logic [SEV_W-1:0] r_best_sev;
    logic [TW-1:0]    r_best_tag;
    logic [SEQ_W-1:0] r_best_seq;
    logic [IW-1:0]    r_best_idx;

    logic             r_out_valid;
    logic [1:0]       r_out_status;
    logic [SEV_W-1:0] r_out_sev;
    logic [TAG_W-1:0] r_out_tag;
    logic [SEQ_W-1:0] r_out_seq;
    logic [OCC_W-1:0] r_out_occ;
    logic             r_out_empty;

    logic             w_in_acc;
    logic             w_out_free;
    logic             w_full;
    logic             w_empty;
    logic             w_issue;
    logic             w_last;
    logic             w_take;
    logic             w_scan_done;
    logic             w_shift_end;
    logic [IW-1:0]    w_best_idx;
    logic [SEV_W-1:0] w_rd_sev;
    logic [TW-1:0]    w_rd_tag;
    logic [SEQ_W-1:0] w_rd_seq;

    logic             mem_wr_en;
    logic [IW-1:0]    mem_wr_addr;
    logic [DW-1:0]    mem_wr_data;
    logic             mem_rd_en;
    logic [DW-1:0]    mem_rd_data;

    spq_store #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IW),
        .DATA_W (DW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (r_ptr[IW-1:0]),
        .o_rd_data (mem_rd_data)
    );

    // Handshake and status terms.
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_issue     = (r_ptr < r_count);

    // Fields of the entry returned by the memory.
    assign w_rd_sev = mem_rd_data[DW-1 -: SEV_W];
    assign w_rd_tag = mem_rd_data[SEQ_W +: TW];
    assign w_rd_seq = mem_rd_data[SEQ_W-1:0];

    // Scan compare: the first entry always wins, later ones only when strictly more urgent.
    assign w_take      = (r_rd_idx == '0) || (w_rd_sev > r_best_sev);
    assign w_best_idx  = w_take ? r_rd_idx : r_best_idx;
    assign w_last      = r_rd_vld && (r_rd_idx == IW'(r_count - CW'(1)));
    assign w_scan_done = (r_state == ST_SCAN) && w_last;
    assign w_shift_end = (r_state == ST_SHIFT) && !w_issue && !r_rd_vld;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if ((i_command == CMD_EXTRACT || i_command == CMD_PEEK) && !w_empty) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (w_scan_done) begin
                    n_state = (r_cmd == CMD_EXTRACT) ? ST_SHIFT : ST_DONE;
                end
            end
            ST_SHIFT: begin
                if (w_shift_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Memory port control.
    always_comb begin
        mem_rd_en   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_count[IW-1:0];
        mem_wr_data = {i_severity, i_tag[TW-1:0], r_next_seq};
        case (r_state)
            ST_IDLE: begin
                mem_wr_en = w_in_acc && (i_command == CMD_INSERT) && !w_full;
            end
            ST_SCAN: begin
                mem_rd_en = w_issue;
            end
            ST_SHIFT: begin
                mem_rd_en   = w_issue;
                mem_wr_en   = r_rd_vld;
                mem_wr_addr = r_rd_idx - IW'(1);
                mem_wr_data = mem_rd_data;
            end
            default: begin
                mem_rd_en = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_next_seq <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= mem_rd_en;
            if (r_state == ST_IDLE && w_in_acc && i_command == CMD_INSERT && !w_full) begin
                r_count    <= r_count + CW'(1);
                r_next_seq <= r_next_seq + SEQ_W'(1);
            end else if (w_shift_end) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Read pointer and in-flight read index.
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_ptr[IW-1:0];
        if (r_state == ST_IDLE) begin
            r_ptr <= '0;
        end else if (w_scan_done) begin
            r_ptr <= CW'(w_best_idx) + CW'(1);
        end else if (mem_rd_en) begin
            r_ptr <= r_ptr + CW'(1);
        end
    end

    // Pending result fields.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_in_acc) begin
            r_cmd      <= i_command;
            r_best_sev <= '0;
            r_best_tag <= '0;
            r_best_idx <= '0;
            case (i_command)
                CMD_INSERT: begin
                    r_status   <= w_full ? STS_FULL : STS_OK;
                    r_best_seq <= w_full ? '0 : r_next_seq;
                end
                CMD_EXTRACT, CMD_PEEK: begin
                    r_status   <= w_empty ? STS_EMPTY : STS_OK;
                    r_best_seq <= '0;
                end
                default: begin
                    r_status   <= STS_OK;
                    r_best_seq <= '0;
                end
            endcase
        end else if (r_state == ST_SCAN && r_rd_vld && w_take) begin
            r_best_sev <= w_rd_sev;
            r_best_tag <= w_rd_tag;
            r_best_seq <= w_rd_seq;
            r_best_idx <= r_rd_idx;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_out_free) begin
            r_out_status <= r_status;
            r_out_sev    <= r_best_sev;
            r_out_tag    <= TAG_W'(r_best_tag);
            r_out_seq    <= r_best_seq;
            r_out_occ    <= OCC_W'(r_count);
            r_out_empty  <= w_empty;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_out_severity = r_out_sev;
    assign o_out_tag      = r_out_tag;
    assign o_arrival_seq  = r_out_seq;
    assign o_occupancy    = r_out_occ;
    assign o_queue_empty  = r_out_empty;

`ifndef SYNTHESIS
    // The fill count never passes the capacity.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("fill count above capacity");

    // A scan or gap closing only runs on a non-empty queue.
    a_busy_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN || r_state == ST_SHIFT) |-> !w_empty)
        else $error("scan or shift with empty queue");

    // An accepted insert into a queue with room grows the count by one.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_command == CMD_INSERT && !w_full)
        |=> (r_count == CW'($past(r_count) + CW'(1))))
        else $error("insert did not grow the count");

    // Leaving the result state always presents a result.
    a_done_presents: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && w_out_free) |=> o_out_valid)
        else $error("result lost at output register");
`endif

endmodule

### rtl/core/spq_store.sv
module spq_store #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 56
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    // Entry storage; contents are only meaningful below the fill count.
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### tb/sv/spq_checker.sv
// Scoreboard for the stable priority queue. It watches both channels, keeps a
// shadow copy of the queue contents, predicts one result per accepted request
// and compares every delivered result with the oldest prediction.
module spq_checker #(
    parameter int CAPACITY = 16,
    parameter int TAG_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [1:0]                i_command,
    input  logic [spq_pkg::SEV_W-1:0] i_severity,
    input  logic [spq_pkg::TAG_W-1:0] i_tag,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [1:0]                i_status,
    input  logic [spq_pkg::SEV_W-1:0] i_out_severity,
    input  logic [spq_pkg::TAG_W-1:0] i_out_tag,
    input  logic [spq_pkg::SEQ_W-1:0] i_arrival_seq,
    input  logic [spq_pkg::OCC_W-1:0] i_occupancy,
    input  logic                      i_queue_empty,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_result_count,
    output int                        o_full_count,
    output int                        o_empty_count
);

    import spq_pkg::*;

    // Tags are kept to their low TAG_BITS bits.
    localparam logic [TAG_W-1:0] TAG_KEEP = (TAG_BITS >= TAG_W) ? {TAG_W{1'b1}} :
                                            TAG_W'((64'd1 << TAG_BITS) - 64'd1);

    typedef struct packed {
        logic [SEV_W-1:0] sev;
        logic [TAG_W-1:0] tag;
        logic [SEQ_W-1:0] seq;
    } t_held_entry;

    typedef struct packed {
        logic [1:0]       status;
        logic [SEV_W-1:0] sev;
        logic [TAG_W-1:0] tag;
        logic [SEQ_W-1:0] seq;
        logic [OCC_W-1:0] occ;
        logic             empty;
    } t_queue_result;

    // Shadow queue in arrival order, so the lowest index is the earliest arrival.
    t_held_entry   shadow_entries[$];
    logic [SEQ_W-1:0] shadow_next_seq = '0;
    t_queue_result expected_results[$];
    t_queue_result want;
    int            mismatch_total = 0;
    int            result_total   = 0;
    int            full_total     = 0;
    int            empty_total    = 0;

    // Apply one request to the shadow queue and return the result it should give.
    function automatic t_queue_result predict_result(input logic [1:0] cmd,
                                                     input logic [SEV_W-1:0] sev,
                                                     input logic [TAG_W-1:0] tag);
        t_queue_result r;
        t_held_entry   e;
        int            best;
        r = '0;
        case (cmd)
            CMD_INSERT: begin
                if (shadow_entries.size() >= CAPACITY) begin
                    r.status = STS_FULL;
                end else begin
                    e.sev = sev;
                    e.tag = tag & TAG_KEEP;
                    e.seq = shadow_next_seq;
                    r.seq = shadow_next_seq;
                    shadow_next_seq = shadow_next_seq + SEQ_W'(1);
                    shadow_entries.push_back(e);
                end
            end
            CMD_EXTRACT, CMD_PEEK: begin
                if (shadow_entries.size() == 0) begin
                    r.status = STS_EMPTY;
                end else begin
                    // Strictly greater wins, so ties stay with the earliest arrival.
                    best = 0;
                    for (int i = 1; i < shadow_entries.size(); i++) begin
                        if (shadow_entries[i].sev > shadow_entries[best].sev) begin
                            best = i;
                        end
                    end
                    r.sev = shadow_entries[best].sev;
                    r.tag = shadow_entries[best].tag;
                    r.seq = shadow_entries[best].seq;
                    if (cmd == CMD_EXTRACT) begin
                        shadow_entries.delete(best);
                    end
                end
            end
            default: begin
                // The unused code leaves the queue untouched.
            end
        endcase
        r.occ   = OCC_W'(shadow_entries.size());
        r.empty = (shadow_entries.size() == 0);
        return r;
    endfunction

    task automatic report_field(input string name, input logic [31:0] exp_val,
                                input logic [31:0] act_val);
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, name, exp_val, act_val);
        mismatch_total++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // A result always belongs to an earlier request, so compare it first.
            if (i_out_valid && !i_out_stall) begin
                result_total++;
                if (expected_results.size() == 0) begin
                    $display("%0t: result with no request waiting, status %0d occupancy %0d",
                             $time, i_status, i_occupancy);
                    mismatch_total++;
                end else begin
                    want = expected_results.pop_front();
                    if (want.status !== i_status)
                        report_field("status", 32'(want.status), 32'(i_status));
                    if (want.sev !== i_out_severity)
                        report_field("out_severity", 32'(want.sev), 32'(i_out_severity));
                    if (want.tag !== i_out_tag)
                        report_field("out_tag", 32'(want.tag), 32'(i_out_tag));
                    if (want.seq !== i_arrival_seq)
                        report_field("arrival_seq", 32'(want.seq), 32'(i_arrival_seq));
                    if (want.occ !== i_occupancy)
                        report_field("occupancy", 32'(want.occ), 32'(i_occupancy));
                    if (want.empty !== i_queue_empty)
                        report_field("queue_empty", 32'(want.empty), 32'(i_queue_empty));
                end
            end

            // Predict the result of a newly accepted request.
            if (i_in_valid && !i_in_stall) begin
                want = predict_result(i_command, i_severity, i_tag);
                if (want.status == STS_FULL) full_total++;
                if (want.status == STS_EMPTY) empty_total++;
                expected_results.push_back(want);
            end
        end
        o_fail_count   <= mismatch_total;
        o_pending      <= expected_results.size();
        o_result_count <= result_total;
        o_full_count   <= full_total;
        o_empty_count  <= empty_total;
    end

endmodule

### tb/sv/tb.sv
// Stimulus and verdict for the stable priority queue. Requests go out in
// bursts with random gaps while the result side stalls in changing patterns.
module tb;
    import spq_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         RANDOM_REQS = 750;
    localparam int         IDLE_LIMIT  = 2000;
    localparam int         DRAIN_WAIT  = 40;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             in_valid    = 1'b0;
    logic             in_stall;
    logic [1:0]       command     = CMD_INSERT;
    logic [SEV_W-1:0] severity    = '0;
    logic [TAG_W-1:0] tag         = '0;
    logic             out_valid;
    logic             out_stall   = 1'b0;
    logic [1:0]       status;
    logic [SEV_W-1:0] out_severity;
    logic [TAG_W-1:0] out_tag;
    logic [SEQ_W-1:0] arrival_seq;
    logic [OCC_W-1:0] occupancy;
    logic             queue_empty;

    int fail_count;
    int pending;
    int result_count;
    int full_count;
    int empty_count;

    int burst_left  = 0;
    int sent_insert = 0;
    int sent_extract = 0;
    int sent_peek   = 0;
    int sent_unused = 0;

    stable_priority_queue #(
        .CAPACITY(16),
        .TAG_BITS(16)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_command     (command),
        .i_severity    (severity),
        .i_tag         (tag),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_status      (status),
        .o_out_severity(out_severity),
        .o_out_tag     (out_tag),
        .o_arrival_seq (arrival_seq),
        .o_occupancy   (occupancy),
        .o_queue_empty (queue_empty)
    );

    spq_checker #(
        .CAPACITY(16),
        .TAG_BITS(16)
    ) checker_inst (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_command     (command),
        .i_severity    (severity),
        .i_tag         (tag),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_status      (status),
        .i_out_severity(out_severity),
        .i_out_tag     (out_tag),
        .i_arrival_seq (arrival_seq),
        .i_occupancy   (occupancy),
        .i_queue_empty (queue_empty),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_result_count(result_count),
        .o_full_count  (full_count),
        .o_empty_count (empty_count)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result-side stall pattern: the mode changes every so often, and one mode
    // never stalls so that back-to-back results are seen too.
    int stall_mode   = 0;
    int mode_left    = 0;
    int stall_phase  = 0;

    always @(posedge clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 150);
        end
        mode_left--;
        stall_phase++;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ((stall_phase % 16) < 8);
        endcase
    end

    // Watchdog on cycles in which neither channel moves a request or result.
    int idle_cycles = 0;

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("stable_priority_queue regression: fail");
            $finish;
        end
    end

    // Present one request and hold it until the block takes it. A new burst
    // may start with a gap in which valid is low.
    task automatic send_request(input logic [1:0] cmd, input logic [SEV_W-1:0] sev,
                                input logic [TAG_W-1:0] tg);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid <= 1'b1;
        command  <= cmd;
        severity <= sev;
        tag      <= tg;
        case (cmd)
            CMD_INSERT:  sent_insert++;
            CMD_EXTRACT: sent_extract++;
            CMD_PEEK:    sent_peek++;
            default:     sent_unused++;
        endcase
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    initial begin
        int               insert_pct;
        int               sev_style;
        int               roll;
        logic [1:0]       cmd;
        logic [SEV_W-1:0] sev;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty queue: extract, peek and the unused code.
        send_request(CMD_EXTRACT, 8'hFF, 16'hFFFF);
        send_request(CMD_PEEK, 8'h00, 16'h0000);
        send_request(CMD_UNUSED, 8'hA5, 16'h5A5A);

        // Fill to capacity with extreme values and a severity tie near the front.
        send_request(CMD_INSERT, 8'h00, 16'h0000);
        send_request(CMD_INSERT, 8'hFF, 16'hFFFF);
        send_request(CMD_INSERT, 8'hFF, 16'h5A5A);
        for (int i = 3; i < 16; i++) begin
            send_request(CMD_INSERT, 8'(i * 19), 16'($urandom));
        end

        // Full queue: a rejected insert, the unused code, then the tie broken
        // by arrival order.
        send_request(CMD_INSERT, 8'hFF, 16'hA5A5);
        send_request(CMD_UNUSED, 8'h00, 16'h0000);
        send_request(CMD_PEEK, 8'h00, 16'h0000);
        send_request(CMD_EXTRACT, 8'h00, 16'h0000);
        send_request(CMD_EXTRACT, 8'h00, 16'h0000);

        // Random traffic. The insert share changes every few dozen requests so
        // the queue swings between empty and full.
        insert_pct = 50;
        sev_style  = 0;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n % 30 == 0) begin
                case ($urandom_range(0, 2))
                    0:       insert_pct = 85;
                    1:       insert_pct = 50;
                    default: insert_pct = 15;
                endcase
                sev_style = $urandom_range(0, 2);
            end
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                cmd = CMD_UNUSED;
            end else if (roll < 15) begin
                cmd = CMD_PEEK;
            end else if ($urandom_range(0, 99) < insert_pct) begin
                cmd = CMD_INSERT;
            end else begin
                cmd = CMD_EXTRACT;
            end
            // Narrow severities give many ties; the wide range covers every bit.
            case (sev_style)
                0:       sev = SEV_W'($urandom_range(0, 3));
                1:       sev = SEV_W'($urandom);
                default: sev = ($urandom_range(0, 1) == 1) ? 8'hFF :
                               SEV_W'($urandom_range(0, 1));
            endcase
            send_request(cmd, sev, 16'($urandom));
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Requests: %0d insert, %0d extract, %0d peek, %0d unused code.",
                 sent_insert, sent_extract, sent_peek, sent_unused);
        $display("Results checked: %0d, with %0d rejected inserts and %0d empty reads.",
                 result_count, full_count, empty_count);
        if (fail_count == 0 && pending == 0) begin
            $display("stable_priority_queue regression: pass");
        end else begin
            $display("stable_priority_queue regression: fail");
        end
        $finish;
    end

endmodule
